// File: sv/n_step_discounted_return_defines.svh
// ----------------------------------------------------------------------------
// n_step_discounted_return_defines.svh
// Assertion macros for the n-step discounted return block.
// ----------------------------------------------------------------------------
`ifndef N_STEP_DISCOUNTED_RETURN_DEFINES_SVH
`define N_STEP_DISCOUNTED_RETURN_DEFINES_SVH

`ifndef SYNTHESIS
// concurrent check on clk_i, quiet while in reset
`define NSDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nsdr assertion failed");
// concurrent check on clk_i, also active during reset
`define NSDR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nsdr assertion failed");
`else
`define NSDR_ASSERT(lbl, prop)
`define NSDR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: sv/nsdr_pkg.sv
// ----------------------------------------------------------------------------
// nsdr_pkg
// Shared constants, payload types and control codes of the n-step return block.
// ----------------------------------------------------------------------------
package nsdr_pkg;

  // window geometry
  localparam int WINDOW_STEPS = 8;
  localparam int COUNT_W      = $clog2(WINDOW_STEPS + 1);
  localparam int IDX_W        = (WINDOW_STEPS > 1) ? $clog2(WINDOW_STEPS) : 1;

  // fixed-point widths
  localparam int GAMMA_W = 17;
  localparam int MUL_W   = 49;                                   // |r * p| <= 2^47
  localparam int TERM_W  = 33;                                   // rounded Q16.16 term
  localparam int ACC_W   = TERM_W + $clog2(WINDOW_STEPS + 2);    // sum of N+1 terms

  localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 17'd65536;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 17'd64881;

  // configuration port
  localparam int PADDR_W = 3;
  localparam logic CFG_IDX_DISCOUNT = 1'b0;

  // shared unit operations
  localparam int MAC_OP_W = 3;
  localparam logic [MAC_OP_W-1:0] MAC_NOP     = 3'd0;
  localparam logic [MAC_OP_W-1:0] MAC_INIT    = 3'd1;  // acc = 0, p = one
  localparam logic [MAC_OP_W-1:0] MAC_TERM    = 3'd2;  // product = operand * p
  localparam logic [MAC_OP_W-1:0] MAC_ACC_POW = 3'd3;  // acc += rnd(product), product = p * g
  localparam logic [MAC_OP_W-1:0] MAC_POW_UPD = 3'd4;  // p = rnd(product)
  localparam logic [MAC_OP_W-1:0] MAC_ACC     = 3'd5;  // acc += rnd(product)

  typedef struct packed {
    logic [15:0]        state_tag;
    logic [7:0]         action_taken;
    logic signed [31:0] step_reward;
    logic signed [31:0] bootstrap_value;
    logic               episode_done;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_state_tag;
    logic [7:0]         out_action;
    logic signed [31:0] discounted_return;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        tag;
    logic [7:0]         action;
    logic signed [31:0] reward;
  } win_entry_t;

  typedef struct packed {
    logic [MAC_OP_W-1:0] op;
    logic signed [31:0]  operand;
  } mac_ctrl_t;

endpackage

// File: sv/nsdr_window.sv
// ----------------------------------------------------------------------------
// nsdr_window
// Shift line holding the steps of the window, oldest at entry zero.
// ----------------------------------------------------------------------------
module nsdr_window import nsdr_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_idx_i,
  input  win_entry_t         wr_entry_i,
  input  logic               shift_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  output logic signed [31:0] rd_reward_o,
  output win_entry_t         head_o
);

  win_entry_t entry_q [WINDOW_STEPS];

  // append at the fill position, or drop the oldest step
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_idx_i] <= wr_entry_i;
    end else if (shift_i) begin
      for (int i = 0; i < WINDOW_STEPS - 1; i++) begin
        entry_q[i] <= entry_q[i + 1];
      end
    end
  end

  assign rd_reward_o = entry_q[rd_idx_i].reward;
  assign head_o      = entry_q[0];

endmodule

// File: sv/nsdr_mac.sv
// ----------------------------------------------------------------------------
// nsdr_mac
// Shared multiplier with accumulator and running power of gamma.
// ----------------------------------------------------------------------------
module nsdr_mac import nsdr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic [GAMMA_W-1:0] gamma_i,
  output logic signed [31:0] ret_o
);

  logic signed [MUL_W-1:0] mul_q, mul_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [GAMMA_W-1:0]      pow_q, pow_d;

  logic signed [TERM_W-1:0]      a_op;
  logic [GAMMA_W-1:0]            b_op;
  logic signed [TERM_W+GAMMA_W:0] prod;
  logic signed [MUL_W-1:0]       rnd_sum;
  logic signed [TERM_W-1:0]      term;

  // operand select for the single multiplier
  always_comb begin
    if (ctrl_i.op == MAC_ACC_POW) begin
      a_op = $signed({{(TERM_W-GAMMA_W){1'b0}}, pow_q});
      b_op = gamma_i;
    end else begin
      a_op = {ctrl_i.operand[31], ctrl_i.operand};
      b_op = pow_q;
    end
  end

  assign prod    = a_op * $signed({1'b0, b_op});
  assign rnd_sum = mul_q + MUL_W'(32768);
  assign term    = rnd_sum[MUL_W-1:16];

  // step the accumulator and power registers per operation
  always_comb begin
    mul_d = mul_q;
    acc_d = acc_q;
    pow_d = pow_q;
    case (ctrl_i.op)
      MAC_INIT: begin
        acc_d = '0;
        pow_d = GAMMA_ONE;
      end
      MAC_TERM: begin
        mul_d = prod[MUL_W-1:0];
      end
      MAC_ACC_POW: begin
        acc_d = acc_q + ACC_W'(term);
        mul_d = prod[MUL_W-1:0];
      end
      MAC_POW_UPD: begin
        pow_d = rnd_sum[GAMMA_W+15:16];
      end
      MAC_ACC: begin
        acc_d = acc_q + ACC_W'(term);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pow_q <= GAMMA_ONE;
    end else begin
      acc_q <= acc_d;
      pow_q <= pow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end

  // saturate to signed 32 bits
  always_comb begin
    if (acc_q[ACC_W-1:31] == '0 || acc_q[ACC_W-1:31] == '1) begin
      ret_o = acc_q[31:0];
    end else if (acc_q[ACC_W-1]) begin
      ret_o = 32'sh8000_0000;
    end else begin
      ret_o = 32'sh7FFF_FFFF;
    end
  end

endmodule

// File: sv/n_step_discounted_return.sv
// ----------------------------------------------------------------------------
// n_step_discounted_return
// N-step discounted return over a sliding window of experience steps.
// ----------------------------------------------------------------------------
// Each accepted step is appended to an eight-step window. A step that neither
// fills the window nor ends the episode produces no result. A full window
// produces one bootstrapped result for its oldest step; a done step flushes
// the whole window, oldest first, last_of_run on the final one. Every window
// term goes through one shared multiplier as reward times power, then power
// times gamma, then the power update; a full-window result adds a bootstrap
// term after the window terms. The input is stalled while results are
// computed; the output register lets a new step be taken while the last
// result still waits.
// ----------------------------------------------------------------------------
`include "n_step_discounted_return_defines.svh"

module n_step_discounted_return import nsdr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // step input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TMUL = 3'd1;
  localparam logic [2:0] ST_TACC = 3'd2;
  localparam logic [2:0] ST_PUPD = 3'd3;
  localparam logic [2:0] ST_BMUL = 3'd4;
  localparam logic [2:0] ST_BACC = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic               flush_q, flush_d;
  logic signed [31:0] boot_q, boot_d;
  logic [GAMMA_W-1:0] discount_q;
  logic               out_valid_q;
  out_item_t          out_q;

  mac_ctrl_t          mac_ctrl;
  logic [GAMMA_W-1:0] gamma;
  logic signed [31:0] ret;
  logic               win_wr;
  logic               win_shift;
  win_entry_t         win_in;
  win_entry_t         win_head;
  logic signed [31:0] rd_reward;
  logic               out_load;
  logic               k_last;
  logic               cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_DISCOUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q <= GAMMA_RESET;
    end else if (cfg_wr) begin
      discount_q <= pwdata[GAMMA_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_DISCOUNT) ? {{(32-GAMMA_W){1'b0}}, discount_q} : '0;
  assign gamma  = (discount_q > GAMMA_ONE) ? GAMMA_ONE : discount_q;

  // window and shared unit
  assign win_in = '{tag: in_data_i.state_tag, action: in_data_i.action_taken,
                    reward: in_data_i.step_reward};

  nsdr_window u_window (
    .clk_i      (clk_i),
    .wr_en_i    (win_wr),
    .wr_idx_i   (count_q[IDX_W-1:0]),
    .wr_entry_i (win_in),
    .shift_i    (win_shift),
    .rd_idx_i   (k_q),
    .rd_reward_o(rd_reward),
    .head_o     (win_head)
  );

  nsdr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .gamma_i(gamma),
    .ret_o  (ret)
  );

  assign k_last = (COUNT_W'(k_q) == count_q - COUNT_W'(1));

  // sequencer
  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    k_d              = k_q;
    flush_d          = flush_q;
    boot_d           = boot_q;
    mac_ctrl.op      = MAC_NOP;
    mac_ctrl.operand = rd_reward;
    win_wr           = 1'b0;
    win_shift        = 1'b0;
    out_load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          win_wr  = 1'b1;
          count_d = count_q + COUNT_W'(1);
          boot_d  = in_data_i.bootstrap_value;
          flush_d = in_data_i.episode_done;
          if (in_data_i.episode_done || count_q == COUNT_W'(WINDOW_STEPS - 1)) begin
            mac_ctrl.op = MAC_INIT;
            k_d         = '0;
            state_d     = ST_TMUL;
          end
        end
      end
      ST_TMUL: begin
        mac_ctrl.op = MAC_TERM;
        state_d     = ST_TACC;
      end
      ST_TACC: begin
        mac_ctrl.op = MAC_ACC_POW;
        state_d     = ST_PUPD;
      end
      ST_PUPD: begin
        mac_ctrl.op = MAC_POW_UPD;
        if (k_last) begin
          state_d = flush_q ? ST_EMIT : ST_BMUL;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = ST_TMUL;
        end
      end
      ST_BMUL: begin
        mac_ctrl.op      = MAC_TERM;
        mac_ctrl.operand = boot_q;
        state_d          = ST_BACC;
      end
      ST_BACC: begin
        mac_ctrl.op = MAC_ACC;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load  = 1'b1;
          win_shift = 1'b1;
          count_d   = count_q - COUNT_W'(1);
          if (flush_q && count_q != COUNT_W'(1)) begin
            mac_ctrl.op = MAC_INIT;
            k_d         = '0;
            state_d     = ST_TMUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      k_q     <= '0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    boot_q <= boot_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_state_tag     <= win_head.tag;
      out_q.out_action        <= win_head.action;
      out_q.discounted_return <= ret;
      out_q.last_of_run       <= !flush_q || (count_q == COUNT_W'(1));
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `NSDR_ASSERT(a_idle_not_full, (state_q == ST_IDLE) |-> (count_q < COUNT_W'(WINDOW_STEPS)))
  `NSDR_ASSERT(a_term_in_window,
    (state_q == ST_TMUL || state_q == ST_TACC || state_q == ST_PUPD) |-> (COUNT_W'(k_q) < count_q))
  `NSDR_ASSERT(a_boot_needs_full,
    (state_q == ST_BMUL) |-> (!flush_q && count_q == COUNT_W'(WINDOW_STEPS)))
  `NSDR_ASSERT(a_load_when_free, out_load |-> (!out_valid_q || !out_stall_i))

endmodule

// File: dv/n_step_discounted_return_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_step_discounted_return_tb
// Self-checking testbench for the n-step discounted return window.
// ----------------------------------------------------------------------------
// Experience steps go in over the valid/stall input with random gaps, and
// results are taken with random output stalls. An in-bench model keeps its
// own step window and discount setting and computes the fixed-point returns
// that each accepted step should cause; every result is checked field by field
// in order. The discount register is set over APB between phases and read
// back. Directed tests hit field extremes, saturation, gamma at zero, one and
// above one, and a done step on a full window. Random episodes and a phase
// with long output back-pressure follow.
// ----------------------------------------------------------------------------
module n_step_discounted_return_tb;
  import nsdr_pkg::*;

  localparam int     CLK_HALF         = 10;
  localparam int     RESET_CYCLES     = 12;
  localparam int     SETTLE_CYCLES    = 40;        // longer than a full-window result
  localparam int     LONG_HOLD_CYCLES = 300;
  localparam int     MAX_REPORTS      = 30;
  localparam int     PHASE_STEPS      = 48;
  localparam longint TIMEOUT_NS       = 64'd20_000_000;

  // register map
  localparam int                 UNUSED_REG_IDX = 1;
  localparam logic [PADDR_W-1:0] DISCOUNT_ADDR  = PADDR_W'(4 * int'(CFG_IDX_DISCOUNT));
  localparam logic [PADDR_W-1:0] UNUSED_ADDR    = PADDR_W'(4 * UNUSED_REG_IDX);

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // model of the window and the discount register
  logic [GAMMA_W-1:0] gamma_reg;
  longint             win_reward [WINDOW_STEPS];
  logic [15:0]        win_tag    [WINDOW_STEPS];
  logic [7:0]         win_action [WINDOW_STEPS];
  int                 win_fill;
  out_item_t          expected_returns [$];

  // run bookkeeping
  int mismatch_count;
  int steps_sent;
  int returns_checked;
  int boot_returns;
  int episode_flushes;
  int hold_cycles;
  bit idle_off;

  n_step_discounted_return DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Return prediction
  // ---------------------------------------------------------------------------

  // Q16.32 -> Q16.16, halves rounded up
  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // discounted sum over the n oldest steps, optional bootstrap term
  function automatic longint discounted_sum(int n, bit add_boot, longint boot);
    longint acc;
    longint pw;
    longint g;
    acc = 0;
    pw  = 65536;
    g   = (gamma_reg > GAMMA_ONE) ? longint'(GAMMA_ONE) : longint'(gamma_reg);
    for (int k = 0; k < n; k++) begin
      acc += round_q16(win_reward[k] * pw);
      pw = (pw * g + 32768) >>> 16;
    end
    if (add_boot) acc += round_q16(boot * pw);
    return acc;
  endfunction

  function automatic logic signed [31:0] saturate_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void push_return(longint ret, bit last);
    out_item_t r;
    r.out_state_tag     = win_tag[0];
    r.out_action        = win_action[0];
    r.discounted_return = saturate_q16(ret);
    r.last_of_run       = last;
    expected_returns = {expected_returns, r};
  endfunction

  function automatic void drop_oldest_step();
    for (int k = 1; k < win_fill; k++) begin
      win_reward[k-1] = win_reward[k];
      win_tag[k-1]    = win_tag[k];
      win_action[k-1] = win_action[k];
    end
    if (win_fill > 0) win_fill--;
  endfunction

  // append one accepted step and queue the results it causes
  function automatic void predict_step_returns(in_item_t s);
    if (win_fill >= WINDOW_STEPS) win_fill = WINDOW_STEPS - 1;
    win_reward[win_fill] = longint'($signed(s.step_reward));
    win_tag[win_fill]    = s.state_tag;
    win_action[win_fill] = s.action_taken;
    win_fill++;
    if (s.episode_done) begin
      // terminal step: flush everything, no bootstrap
      episode_flushes++;
      while (win_fill > 0) begin
        push_return(discounted_sum(win_fill, 1'b0, 0), win_fill == 1);
        drop_oldest_step();
      end
    end else if (win_fill == WINDOW_STEPS) begin
      boot_returns++;
      push_return(discounted_sum(WINDOW_STEPS, 1'b1, longint'($signed(s.bootstrap_value))),
                  1'b1);
      drop_oldest_step();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_step(logic [15:0] tag, logic [7:0] act,
                                         logic [31:0] rew, logic [31:0] boot,
                                         logic done);
    in_item_t s;
    s.state_tag       = tag;
    s.action_taken    = act;
    s.step_reward     = rew;
    s.bootstrap_value = boot;
    s.episode_done    = done;
    return s;
  endfunction

  // mostly small rewards (about +-8.0), some full-range and extremes
  function automatic logic [31:0] random_q16();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(20'hF_FFFF)) - 32'd524288;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // one step transaction; called and returns at a falling edge
  task automatic send_step(input in_item_t s);
    while (!idle_off && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_step_returns(s);
    steps_sent++;
    @(negedge clk_i);
  endtask

  // sender pause until every expected result has come, then let the block settle
  task automatic wait_returns_drained();
    in_valid_i <= 1'b0;
    while (expected_returns.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == DISCOUNT_ADDR) gamma_reg = data[GAMMA_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_discount_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DISCOUNT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(gamma_reg))
      report_mismatch($sformatf("discount readback %h, want %h", prdata, 32'(gamma_reg)));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // register writes only with the block idle
  task automatic set_discount(input logic [31:0] value);
    wait_returns_drained();
    apb_write(DISCOUNT_ADDR, value);
    check_discount_readback();
  endtask

  // random episodes: mostly complete runs of random length, a little stray done noise
  task automatic run_episodes(input int n_steps);
    int  left;
    bit  done;
    left = 0;
    for (int i = 0; i < n_steps; i++) begin
      if (left == 0)
        left = ($urandom_range(3) == 0) ? $urandom_range(1, WINDOW_STEPS)
                                        : $urandom_range(WINDOW_STEPS + 1, 30);
      left--;
      done = (left == 0) || ($urandom_range(99) < 3);
      if (done) left = 0;
      send_step(make_step(16'($urandom), 8'($urandom), random_q16(), random_q16(), done));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset discount value, then a done step on an empty window
  task automatic test_reset_and_single_flush();
    check_discount_readback();
    send_step(make_step(16'hFFFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
  endtask

  // gamma exactly one: full window saturates high, one more slide, then a full flush
  task automatic test_unity_gamma_window();
    set_discount(32'(GAMMA_ONE));
    for (int i = 0; i < WINDOW_STEPS; i++)
      send_step(make_step(16'(i), 8'(8'hF0 + i), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_step(make_step(16'h0000, 8'h00, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_step(make_step(16'h5A5A, 8'hA5, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1));
  endtask

  // gamma zero, window full and done on the same step
  task automatic test_zero_gamma_full_and_done();
    set_discount(32'd0);
    for (int i = 0; i < WINDOW_STEPS; i++)
      send_step(make_step(16'hFF00 | 16'(i), 8'(i), 32'h8000_0000, 32'h7FFF_FFFF,
                          i == WINDOW_STEPS - 1));
  endtask

  // unused register ignored; gamma above one behaves as one, saturates low
  task automatic test_gamma_above_one();
    wait_returns_drained();
    apb_write(UNUSED_ADDR, 32'h0000_1234);
    check_discount_readback();
    set_discount(32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++)
      send_step(make_step(16'h1234 + 16'(i), 8'h3C, 32'h8000_0000, 32'h8000_0000, i == 2));
  endtask

  // several gamma settings, one phase without any idling
  task automatic test_random_episodes();
    set_discount(32'(GAMMA_RESET));
    run_episodes(PHASE_STEPS);
    set_discount($urandom_range(32'(GAMMA_ONE), 32'd49152));
    idle_off = 1'b1;
    run_episodes(PHASE_STEPS);
    idle_off = 1'b0;
    set_discount(32'd65535);
    run_episodes(PHASE_STEPS);
    set_discount($urandom_range(32'(GAMMA_ONE)));
    run_episodes(PHASE_STEPS);
  endtask

  // long output hold while steps keep coming, so the block backs up
  task automatic test_output_backpressure();
    set_discount(32'(GAMMA_RESET));
    hold_cycles = LONG_HOLD_CYCLES;
    for (int i = 0; i < 14; i++)
      send_step(make_step(16'($urandom), 8'($urandom), random_q16(), random_q16(), 1'b0));
    wait_returns_drained();
    send_step(make_step(16'($urandom), 8'($urandom), random_q16(), random_q16(), 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= !idle_off && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin : check_returns
    out_item_t want;
    string     bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_returns.size() == 0) begin
        report_mismatch($sformatf("unexpected result tag %h act %h ret %h last %b",
                                  out_data_o.out_state_tag, out_data_o.out_action,
                                  out_data_o.discounted_return, out_data_o.last_of_run));
      end else begin
        want = expected_returns[0];
        expected_returns.delete(0);
        returns_checked++;
        bad = "";
        if (out_data_o.out_state_tag !== want.out_state_tag) bad = {bad, " tag"};
        if (out_data_o.out_action !== want.out_action) bad = {bad, " action"};
        if (out_data_o.discounted_return !== want.discounted_return) bad = {bad, " return"};
        if (out_data_o.last_of_run !== want.last_of_run) bad = {bad, " last"};
        if (bad != "")
          report_mismatch($sformatf(
            "result %0d wrong%s: got %h/%h/%h/%b want %h/%h/%h/%b", returns_checked, bad,
            out_data_o.out_state_tag, out_data_o.out_action, out_data_o.discounted_return,
            out_data_o.last_of_run, want.out_state_tag, want.out_action,
            want.discounted_return, want.last_of_run));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    out_stall_i     = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    gamma_reg       = GAMMA_RESET;
    win_fill        = 0;
    mismatch_count  = 0;
    steps_sent      = 0;
    returns_checked = 0;
    boot_returns    = 0;
    episode_flushes = 0;
    hold_cycles     = 0;
    idle_off        = 1'b0;

    // count rising edges so the start-up transition of the clock does not count
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_and_single_flush();
    test_unity_gamma_window();
    test_zero_gamma_full_and_done();
    test_gamma_above_one();
    test_random_episodes();
    test_output_backpressure();
    wait_returns_drained();

    $display("Sent %0d steps, checked %0d results (%0d bootstrapped, %0d episode flushes)",
             steps_sent, returns_checked, boot_returns, episode_flushes);
    $display("Discount settings: reset, zero, one, above one, near one and random");
    if (mismatch_count == 0 && expected_returns.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_returns.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d results still expected", expected_returns.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/nsdr_pkg.sv
sv/nsdr_window.sv
sv/nsdr_mac.sv
sv/n_step_discounted_return.sv
dv/n_step_discounted_return_tb.sv
